FILE: design/csfg_pkg.sv
// shared types, widths and codes for the core scalability frequency governor
// no dependencies; imported by the interfaces and every module of the block
package csfg_pkg;

  localparam int CORE_W = 6;
  localparam int CNT_W  = 64;
  localparam int HALF_W = 32;
  localparam int FREQ_W = 14;
  localparam int TH_W   = 11;
  localparam int STEP_W = 10;
  localparam int REQ_W  = FREQ_W + 2;
  localparam int CIDX_W = 3;

  typedef enum logic [CIDX_W-1:0] {
    CFG_LOW_TH  = 3'd0,
    CFG_HIGH_TH = 3'd1,
    CFG_START   = 3'd2,
    CFG_MAX     = 3'd3,
    CFG_MIN     = 3'd4,
    CFG_STEP    = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DEC_HOLD  = 2'd0,
    DEC_DOWN  = 2'd1,
    DEC_UP    = 2'd2,
    DEC_UNDEF = 2'd3
  } dec_t;

  typedef struct packed {
    logic [TH_W-1:0]   low_th;
    logic [TH_W-1:0]   high_th;
    logic [FREQ_W-1:0] boot_freq;
    logic [FREQ_W-1:0] max_freq;
    logic [FREQ_W-1:0] min_freq;
    logic [STEP_W-1:0] step;
  } cfg_t;

  typedef struct packed {
    logic [FREQ_W-1:0] act;
    logic              chg;
  } cand_t;

  // max clamp checked first, so crossed limits resolve to max when above it
  function automatic logic [FREQ_W-1:0] clamp_req(logic signed [REQ_W-1:0] req,
                                                  logic [FREQ_W-1:0] lo,
                                                  logic [FREQ_W-1:0] hi);
    logic [FREQ_W-1:0] res;
    if (req > $signed({2'b00, hi})) begin
      res = hi;
    end else if (req < $signed({2'b00, lo})) begin
      res = lo;
    end else begin
      res = req[FREQ_W-1:0];
    end
    return res;
  endfunction

  function automatic cand_t make_cand(logic signed [REQ_W-1:0] req,
                                      logic [FREQ_W-1:0] curr,
                                      cfg_t c);
    cand_t r;
    r.act = clamp_req(req, c.min_freq, c.max_freq);
    r.chg = (r.act != curr);
    return r;
  endfunction

endpackage

FILE: design/csfg_intf.sv
// valid/ready channel interfaces: sample input, request output, config writes
// depends on csfg_pkg for field widths
interface csfg_in_if;
  import csfg_pkg::*;
  logic              valid;
  logic              ready;
  logic [CORE_W-1:0] core_index;
  logic [CNT_W-1:0]  active_count;
  logic [CNT_W-1:0]  productive_count;
  logic [FREQ_W-1:0] measured_freq_mhz;
  modport source(output valid, core_index, active_count, productive_count,
                 measured_freq_mhz, input ready);
  modport sink(input valid, core_index, active_count, productive_count,
               measured_freq_mhz, output ready);
endinterface

interface csfg_out_if;
  import csfg_pkg::*;
  logic              valid;
  logic              ready;
  logic [CORE_W-1:0] out_core_index;
  logic [FREQ_W-1:0] request_freq_mhz;
  logic              freq_changed;
  logic [1:0]        decision;
  modport source(output valid, out_core_index, request_freq_mhz, freq_changed,
                 decision, input ready);
  modport sink(input valid, out_core_index, request_freq_mhz, freq_changed,
               decision, output ready);
endinterface

interface csfg_cfg_if;
  import csfg_pkg::*;
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] wr_index;
  logic [FREQ_W-1:0] wr_data;
  modport source(output valid, wr_index, wr_data, input ready);
  modport sink(input valid, wr_index, wr_data, output ready);
endinterface

FILE: design/csfg_cfg_regs.sv
// configuration register file of the governor, always ready for writes
// depends on csfg_pkg and csfg_cfg_if
module csfg_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  csfg_cfg_if.sink        cfg,
  output csfg_pkg::cfg_t  cfg_o
);
  import csfg_pkg::*;

  cfg_t cfg_r;

  assign cfg.ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_th    <= TH_W'(819);
      cfg_r.high_th   <= TH_W'(922);
      cfg_r.boot_freq <= FREQ_W'(2000);
      cfg_r.max_freq  <= FREQ_W'(2800);
      cfg_r.min_freq  <= FREQ_W'(1000);
      cfg_r.step      <= STEP_W'(100);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.wr_index)
        CFG_LOW_TH:  cfg_r.low_th    <= cfg.wr_data[TH_W-1:0];
        CFG_HIGH_TH: cfg_r.high_th   <= cfg.wr_data[TH_W-1:0];
        CFG_START:   cfg_r.boot_freq <= cfg.wr_data;
        CFG_MAX:     cfg_r.max_freq  <= cfg.wr_data;
        CFG_MIN:     cfg_r.min_freq  <= cfg.wr_data;
        CFG_STEP:    cfg_r.step      <= cfg.wr_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: design/csfg_hist.sv
// per-core history of previous counter readings with per-entry valid bits
// depends on csfg_pkg; read returns old value, write stores the new sample
module csfg_hist #(
  parameter int NUM_CORES = 64
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          acc,
  input  logic                                          in_range,
  input  logic [((NUM_CORES > 1) ? $clog2(NUM_CORES) : 1)-1:0] addr,
  input  logic [csfg_pkg::CNT_W-1:0]                    wr_active,
  input  logic [csfg_pkg::CNT_W-1:0]                    wr_productive,
  output logic [csfg_pkg::CNT_W-1:0]                    old_active,
  output logic [csfg_pkg::CNT_W-1:0]                    old_productive
);
  import csfg_pkg::*;

  logic [2*CNT_W-1:0] mem [NUM_CORES];
  logic [NUM_CORES-1:0] valid_r;
  logic [2*CNT_W-1:0] rd_data_r;
  logic               rd_valid_r;

  // entries past the core count are never written and never read as valid
  always_ff @(posedge clk) begin
    if (acc && in_range) begin
      mem[addr] <= {wr_active, wr_productive};
    end
    if (acc) begin
      rd_data_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else if (acc) begin
      rd_valid_r <= in_range && valid_r[addr];
      if (in_range) begin
        valid_r[addr] <= 1'b1;
      end
    end
  end

  assign old_active     = rd_valid_r ? rd_data_r[2*CNT_W-1:CNT_W] : '0;
  assign old_productive = rd_valid_r ? rd_data_r[CNT_W-1:0] : '0;

endmodule

FILE: design/core_scalability_freq_governor.sv
// core scalability frequency governor, top level
// each input item passes through four register stages (s1, s2, s3, out) to the result
// throughput: one item per cycle; input stalls only when all four stages hold items
// and out_ch.ready is low
// reset clears config to defaults, history valid bits and all stage valids at once
// depends on csfg_pkg, csfg_intf, csfg_cfg_regs and csfg_hist
module core_scalability_freq_governor #(
  parameter int NUM_CORES = 64,
  parameter int FRAC_BITS = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  csfg_in_if.sink    in_ch,
  csfg_out_if.source out_ch,
  csfg_cfg_if.sink   cfg_ch
);
  import csfg_pkg::*;

  localparam int AW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int CW = CNT_W + TH_W + FRAC_BITS;
  localparam int PW = HALF_W + TH_W;

  cfg_t cfg;

  csfg_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .cfg_o (cfg)
  );

  // pipeline handshake
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic s1_rdy, s2_rdy, s3_rdy, o_rdy;
  logic in_acc;

  assign o_rdy       = !out_v_r || out_ch.ready;
  assign s3_rdy      = !s3_v_r || o_rdy;
  assign s2_rdy      = !s2_v_r || s3_rdy;
  assign s1_rdy      = !s1_v_r || s2_rdy;
  assign in_ch.ready = s1_rdy;
  assign in_acc      = in_ch.valid && s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_ch.valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) s3_v_r <= s2_v_r;
      if (o_rdy)  out_v_r <= s3_v_r;
    end
  end

  // history lookup
  logic [AW+CORE_W-1:0] idx_ext;
  logic [AW-1:0]        addr;
  logic                 in_range;
  logic [CNT_W-1:0]     old_a, old_p;

  assign idx_ext  = {{AW{1'b0}}, in_ch.core_index};
  assign addr     = idx_ext[AW-1:0];
  assign in_range = (32'(in_ch.core_index) < NUM_CORES);

  csfg_hist #(.NUM_CORES(NUM_CORES)) u_hist (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (in_acc),
    .in_range       (in_range),
    .addr           (addr),
    .wr_active      (in_ch.active_count),
    .wr_productive  (in_ch.productive_count),
    .old_active     (old_a),
    .old_productive (old_p)
  );

  // stage 1: captured sample
  logic [CORE_W-1:0] s1_core_r;
  logic [CNT_W-1:0]  s1_act_r, s1_prod_r;
  logic [FREQ_W-1:0] s1_meas_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_core_r <= in_ch.core_index;
      s1_act_r  <= in_ch.active_count;
      s1_prod_r <= in_ch.productive_count;
      s1_meas_r <= in_ch.measured_freq_mhz;
    end
  end

  // deltas and clamped candidates
  logic [CNT_W-1:0]         da, dp;
  logic                     mz;
  logic [FREQ_W-1:0]        curr;
  logic signed [REQ_W-1:0]  curr_s, step_s;
  cand_t                    c_hold, c_dn, c_up;

  always_comb begin
    da     = s1_act_r - old_a;
    dp     = s1_prod_r - old_p;
    mz     = (s1_meas_r == '0);
    curr   = mz ? cfg.boot_freq : s1_meas_r;
    curr_s = $signed({2'b00, curr});
    step_s = $signed({{(REQ_W-STEP_W){1'b0}}, cfg.step});
    c_hold = make_cand(curr_s, curr, cfg);
    c_dn   = make_cand(curr_s - step_s, curr, cfg);
    c_up   = make_cand(curr_s + step_s, curr, cfg);
  end

  logic [CORE_W-1:0] s2_core_r;
  logic [CNT_W-1:0]  s2_da_r, s2_dp_r;
  logic              s2_mz_r;
  cand_t             s2_hold_r, s2_dn_r, s2_up_r;

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      s2_core_r <= s1_core_r;
      s2_da_r   <= da;
      s2_dp_r   <= dp;
      s2_mz_r   <= mz;
      s2_hold_r <= c_hold;
      s2_dn_r   <= c_dn;
      s2_up_r   <= c_up;
    end
  end

  // stage 2 to 3: threshold products split into 32-bit halves
  logic [CNT_W-1:0] mul_a, numer;
  logic             undef;
  logic [PW-1:0]    p_lo_l, p_hi_l, p_lo_h, p_hi_h;

  always_comb begin
    undef  = !s2_mz_r && (s2_da_r == '0) && (s2_dp_r == '0);
    mul_a  = s2_mz_r ? CNT_W'(1) : s2_da_r;
    numer  = s2_mz_r ? CNT_W'(1) : s2_dp_r;
    p_lo_l = {{TH_W{1'b0}}, mul_a[HALF_W-1:0]} * {{HALF_W{1'b0}}, cfg.low_th};
    p_hi_l = {{TH_W{1'b0}}, mul_a[CNT_W-1:HALF_W]} * {{HALF_W{1'b0}}, cfg.low_th};
    p_lo_h = {{TH_W{1'b0}}, mul_a[HALF_W-1:0]} * {{HALF_W{1'b0}}, cfg.high_th};
    p_hi_h = {{TH_W{1'b0}}, mul_a[CNT_W-1:HALF_W]} * {{HALF_W{1'b0}}, cfg.high_th};
  end

  logic [CORE_W-1:0] s3_core_r;
  logic [CNT_W-1:0]  s3_numer_r;
  logic              s3_undef_r;
  logic [PW-1:0]     s3_p_lo_l_r, s3_p_hi_l_r, s3_p_lo_h_r, s3_p_hi_h_r;
  cand_t             s3_hold_r, s3_dn_r, s3_up_r;

  always_ff @(posedge clk) begin
    if (s3_rdy) begin
      s3_core_r   <= s2_core_r;
      s3_numer_r  <= numer;
      s3_undef_r  <= undef;
      s3_p_lo_l_r <= p_lo_l;
      s3_p_hi_l_r <= p_hi_l;
      s3_p_lo_h_r <= p_lo_h;
      s3_p_hi_h_r <= p_hi_h;
      s3_hold_r   <= s2_hold_r;
      s3_dn_r     <= s2_dn_r;
      s3_up_r     <= s2_up_r;
    end
  end

  // stage 3: combine partials, compare, pick candidate
  logic [CW-1:0] lo_b, hi_b, num;
  dec_t          dec;
  cand_t         sel;

  always_comb begin
    lo_b = (CW'(s3_p_hi_l_r) << HALF_W) + CW'(s3_p_lo_l_r);
    hi_b = (CW'(s3_p_hi_h_r) << HALF_W) + CW'(s3_p_lo_h_r);
    num  = CW'(s3_numer_r) << FRAC_BITS;
    if (s3_undef_r) begin
      dec = DEC_UNDEF;
      sel = s3_hold_r;
    end else if (num < lo_b) begin
      dec = DEC_DOWN;
      sel = s3_dn_r;
    end else if (hi_b < num) begin
      dec = DEC_UP;
      sel = s3_up_r;
    end else begin
      dec = DEC_HOLD;
      sel = s3_hold_r;
    end
  end

  logic [CORE_W-1:0] out_core_r;
  logic [FREQ_W-1:0] out_req_r;
  logic              out_chg_r;
  logic [1:0]        out_dec_r;

  always_ff @(posedge clk) begin
    if (o_rdy) begin
      out_core_r <= s3_core_r;
      out_req_r  <= sel.act;
      out_chg_r  <= sel.chg;
      out_dec_r  <= dec;
    end
  end

  assign out_ch.valid            = out_v_r;
  assign out_ch.out_core_index   = out_core_r;
  assign out_ch.request_freq_mhz = out_req_r;
  assign out_ch.freq_changed     = out_chg_r;
  assign out_ch.decision         = out_dec_r;

endmodule

FILE: test/core_scalability_freq_governor_test.sv
// testbench for the core scalability frequency governor: directed table, then random samples
// under several register settings, each request checked vs table row or per-core predictor
// depends on csfg_pkg, csfg_intf and the core_scalability_freq_governor top level
`timescale 1ns / 1ps

module core_scalability_freq_governor_test;
  import csfg_pkg::*;

  localparam int FRAC_BITS      = 10;
  localparam int NCORE          = 64;
  localparam int NDIR           = 20;
  localparam int NPHASE         = 8;
  localparam int NPRESET        = 4;
  localparam int FIRST_RANDOM   = 130;
  localparam int PHASE_RANDOM   = 155;
  localparam int SETTLE_CYCLES  = 6;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  localparam logic [CIDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CIDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam logic [CNT_W-1:0] ALL1 = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] TOP1 = 64'h8000_0000_0000_0000;
  localparam logic [CNT_W-1:0] PAT5 = 64'h5555_5555_5555_5555;
  localparam logic [CNT_W-1:0] PATA = 64'hAAAA_AAAA_AAAA_AAAA;

  typedef struct packed {
    logic [CORE_W-1:0] core;
    logic [CNT_W-1:0]  acnt;
    logic [CNT_W-1:0]  pcnt;
    logic [FREQ_W-1:0] meas;
    logic              has_exp;
    logic [FREQ_W-1:0] exp_freq;
    logic              exp_chg;
    dec_t              exp_dec;
  } sample_row_t;

  typedef struct packed {
    logic [CORE_W-1:0] core;
    logic [FREQ_W-1:0] freq;
    logic              chg;
    dec_t              dec;
  } request_t;

  // rows typed in against the reset register values
  localparam sample_row_t DIRECTED [NDIR] = '{
    '{6'd0,  64'd0,   64'd0,   14'd1500,  1'b1, 14'd1500, 1'b0, DEC_UNDEF},
    '{6'd63, 64'd5,   64'd7,   14'd0,     1'b1, 14'd2100, 1'b1, DEC_UP},
    '{6'd1,  64'd1000, 64'd1000, 14'd16383, 1'b1, 14'd2800, 1'b1, DEC_UP},
    '{6'd2,  64'd0,   64'd5,   14'd1,     1'b1, 14'd1000, 1'b1, DEC_UP},
    '{6'd3,  ALL1,    64'd0,   14'd2000,  1'b1, 14'd1900, 1'b1, DEC_DOWN},
    '{6'd3,  ALL1,    64'd0,   14'd2000,  1'b1, 14'd2000, 1'b0, DEC_UNDEF},
    '{6'd3,  64'd999, 64'd850, 14'd2000,  1'b1, 14'd2000, 1'b0, DEC_HOLD},
    '{6'd4,  ALL1,    ALL1,    14'd50,    1'b1, 14'd1000, 1'b1, DEC_UP},
    '{6'd5,  64'd100, 64'd10,  14'd50,    1'b1, 14'd1000, 1'b1, DEC_DOWN},
    '{6'd6,  64'd1024, 64'd819, 14'd2800, 1'b1, 14'd2800, 1'b0, DEC_HOLD},
    '{6'd7,  64'd1024, 64'd818, 14'd1000, 1'b1, 14'd1000, 1'b0, DEC_DOWN},
    '{6'd8,  64'd1024, 64'd922, 14'd2800, 1'b1, 14'd2800, 1'b0, DEC_HOLD},
    '{6'd9,  64'd1024, 64'd923, 14'd2750, 1'b1, 14'd2800, 1'b1, DEC_UP},
    '{6'd10, TOP1,    TOP1,    14'd16383, 1'b1, 14'd2800, 1'b1, DEC_UP},
    '{6'd0,  ALL1,    ALL1,    14'd2000,  1'b1, 14'd2100, 1'b1, DEC_UP},
    '{6'd0,  64'd0,   64'd0,   14'd16383, 1'b1, 14'd2800, 1'b1, DEC_UP},
    '{6'd0,  64'd0,   64'd0,   14'd0,     1'b1, 14'd2100, 1'b1, DEC_UP},
    '{6'd63, PAT5,    PATA,    14'h2AAA,  1'b0, 14'd0,    1'b0, DEC_HOLD},
    '{6'd42, PATA,    PAT5,    14'h1555,  1'b0, 14'd0,    1'b0, DEC_HOLD},
    '{6'd63, PAT5,    PAT5,    14'd8191,  1'b0, 14'd0,    1'b0, DEC_HOLD}
  };

  // low, high, start, max, min, step; upper bits above a register's width are dropped
  localparam logic [FREQ_W-1:0] PRESET_REGS [NPRESET][6] = '{
    '{14'h3FFF, 14'h3800, 14'd2000,  14'd2800,  14'd1000, 14'd100},
    '{14'd819,  14'd922,  14'd2000,  14'd1500,  14'd3000, 14'h3FFF},
    '{14'd0,    14'd0,    14'd16383, 14'd16383, 14'd0,    14'd0},
    '{14'd2047, 14'd2047, 14'd0,     14'd16383, 14'd0,    14'd1}
  };

  logic clk;
  logic rst_n;

  csfg_in_if  in_ch();
  csfg_out_if out_ch();
  csfg_cfg_if cfg_ch();

  core_scalability_freq_governor DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  cfg_t              governor_cfg;
  logic [CNT_W-1:0]  hist_active [NCORE];
  logic [CNT_W-1:0]  hist_productive [NCORE];
  logic [CNT_W-1:0]  sent_active [NCORE];
  logic [CNT_W-1:0]  sent_productive [NCORE];
  sample_row_t       sent_rows [$];
  request_t          pending_requests [$];
  int                error_count;
  int                items_taken;
  int                requests_checked;
  int                dec_seen [4];
  int                idle_cycles;
  int                in_quiet;
  int                out_quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic request_t predict_request(input logic [CORE_W-1:0] core,
                                               input logic [CNT_W-1:0] acnt,
                                               input logic [CNT_W-1:0] pcnt,
                                               input logic [FREQ_W-1:0] meas);
    logic [CNT_W-1:0] da;
    logic [CNT_W-1:0] dp;
    logic [79:0]      num;
    logic [79:0]      lo_b;
    logic [79:0]      hi_b;
    int               curr;
    int               req;
    int               act;
    request_t         r;
    da = acnt - hist_active[core];
    dp = pcnt - hist_productive[core];
    hist_active[core] = acnt;
    hist_productive[core] = pcnt;
    if (meas == '0) begin
      curr = int'(governor_cfg.boot_freq);
      num  = 80'(1) << FRAC_BITS;
      lo_b = 80'(governor_cfg.low_th);
      hi_b = 80'(governor_cfg.high_th);
    end else begin
      curr = int'(meas);
      num  = 80'(dp) << FRAC_BITS;
      lo_b = 80'(da) * 80'(governor_cfg.low_th);
      hi_b = 80'(da) * 80'(governor_cfg.high_th);
    end
    if (meas != '0 && da == '0 && dp == '0) begin
      r.dec = DEC_UNDEF;
      req = curr;
    end else if (num < lo_b) begin
      r.dec = DEC_DOWN;
      req = curr - int'(governor_cfg.step);
    end else if (hi_b < num) begin
      r.dec = DEC_UP;
      req = curr + int'(governor_cfg.step);
    end else begin
      r.dec = DEC_HOLD;
      req = curr;
    end
    if (req > int'(governor_cfg.max_freq)) begin
      act = int'(governor_cfg.max_freq);
    end else if (req < int'(governor_cfg.min_freq)) begin
      act = int'(governor_cfg.min_freq);
    end else begin
      act = req;
    end
    r.core = core;
    r.freq = act[FREQ_W-1:0];
    r.chg  = (act != curr);
    return r;
  endfunction

  function automatic int pick_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // mostly counter pairs that advance at a ratio near a threshold
  function automatic sample_row_t gen_sample();
    sample_row_t       s;
    int                kind;
    int                sel;
    int                q;
    int                m;
    logic [CNT_W-1:0]  da;
    logic [CNT_W-1:0]  dp;
    logic [CORE_W-1:0] c;
    logic [FREQ_W-1:0] base;
    s = '0;
    c = CORE_W'($urandom_range(0, NCORE - 1));
    s.core = c;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        q = int'(governor_cfg.low_th) + $urandom_range(0, 6) - 3;
      end else if (sel < 80) begin
        q = int'(governor_cfg.high_th) + $urandom_range(0, 6) - 3;
      end else begin
        q = $urandom_range(0, 2047);
      end
      if (q < 0) q = 0;
      if (q > 2047) q = 2047;
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        da = 64'($urandom_range(1, 1 << 20));
      end else if (sel < 8) begin
        da = {32'd0, $urandom};
      end else if (sel < 9) begin
        da = 64'($urandom_range(1, 16));
      end else begin
        da = '0;
      end
      if (da == '0) begin
        dp = 64'($urandom_range(1, 1000));
      end else begin
        dp = ((da * 64'(q)) >> FRAC_BITS) + 64'($urandom_range(0, 2)) - 64'd1;
      end
      s.acnt = sent_active[c] + da;
      s.pcnt = sent_productive[c] + dp;
    end else if (kind < 80) begin
      s.acnt = sent_active[c];
      s.pcnt = sent_productive[c];
    end else begin
      s.acnt = {$urandom, $urandom};
      s.pcnt = {$urandom, $urandom};
    end
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      s.meas = '0;
    end else if (sel < 6) begin
      case ($urandom_range(0, 2))
        0: base = governor_cfg.min_freq;
        1: base = governor_cfg.max_freq;
        default: base = governor_cfg.boot_freq;
      endcase
      m = int'(base) + int'($urandom_range(0, 2 * int'(governor_cfg.step) + 4))
          - int'(governor_cfg.step) - 2;
      if (m < 0) m = 0;
      if (m > 16383) m = 16383;
      s.meas = m[FREQ_W-1:0];
    end else begin
      s.meas = FREQ_W'($urandom);
    end
    return s;
  endfunction

  task automatic drive_sample(input sample_row_t row);
    int gap;
    gap = pick_gap(in_quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sent_active[row.core] = row.acnt;
    sent_productive[row.core] = row.pcnt;
    sent_rows.insert(sent_rows.size(), row);
    in_ch.valid             <= 1'b1;
    in_ch.core_index        <= row.core;
    in_ch.active_count      <= row.acnt;
    in_ch.productive_count  <= row.pcnt;
    in_ch.measured_freq_mhz <= row.meas;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [FREQ_W-1:0] data);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.wr_index <= idx;
    cfg_ch.wr_data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sent_rows.size() > 0 || pending_requests.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_phase(input int ph);
    logic [FREQ_W-1:0] vals [6];
    int                i;
    if (ph <= NPRESET) begin
      for (i = 0; i < 6; i++) vals[i] = PRESET_REGS[ph-1][i];
    end else begin
      vals[CFG_LOW_TH]  = FREQ_W'($urandom_range(600, 1100));
      vals[CFG_HIGH_TH] = FREQ_W'($urandom_range(700, 1300));
      vals[CFG_START]   = FREQ_W'($urandom);
      vals[CFG_MAX]     = FREQ_W'($urandom_range(1500, 16383));
      vals[CFG_MIN]     = FREQ_W'($urandom_range(0, 3000));
      vals[CFG_STEP]    = FREQ_W'($urandom_range(0, 1023));
      cfg_write(CFG_SPARE_LO, FREQ_W'($urandom));
    end
    for (i = 0; i < 6; i++) cfg_write(cfg_idx_t'(i), vals[i]);
    if (ph > NPRESET) cfg_write(CFG_SPARE_HI, FREQ_W'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    request_t    got;
    request_t    want;
    sample_row_t row;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.core = out_ch.out_core_index;
        got.freq = out_ch.request_freq_mhz;
        got.chg  = out_ch.freq_changed;
        got.dec  = dec_t'(out_ch.decision);
        if (pending_requests.size() == 0) begin
          $error("request with no sample item pending: core %0d", got.core);
          error_count++;
        end else begin
          want = pending_requests.pop_front();
          if (got.core != want.core) begin
            $error("out_core_index expected %0d got %0d", want.core, got.core);
            error_count++;
          end
          if (got.freq != want.freq) begin
            $error("request_freq_mhz expected %0d got %0d", want.freq, got.freq);
            error_count++;
          end
          if (got.chg != want.chg) begin
            $error("freq_changed expected %0d got %0d", want.chg, got.chg);
            error_count++;
          end
          if (got.dec != want.dec) begin
            $error("decision expected %0d got %0d", want.dec, got.dec);
            error_count++;
          end
          dec_seen[got.dec]++;
          requests_checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want = predict_request(in_ch.core_index, in_ch.active_count,
                               in_ch.productive_count, in_ch.measured_freq_mhz);
        if (sent_rows.size() > 0) begin
          row = sent_rows.pop_front();
          if (row.has_exp) begin
            want.freq = row.exp_freq;
            want.chg  = row.exp_chg;
            want.dec  = row.exp_dec;
          end
        end
        pending_requests.insert(pending_requests.size(), want);
        items_taken++;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.wr_index)
          CFG_LOW_TH:  governor_cfg.low_th    = cfg_ch.wr_data[TH_W-1:0];
          CFG_HIGH_TH: governor_cfg.high_th   = cfg_ch.wr_data[TH_W-1:0];
          CFG_START:   governor_cfg.boot_freq = cfg_ch.wr_data;
          CFG_MAX:     governor_cfg.max_freq  = cfg_ch.wr_data;
          CFG_MIN:     governor_cfg.min_freq  = cfg_ch.wr_data;
          CFG_STEP:    governor_cfg.step      = cfg_ch.wr_data[STEP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int run;
    int gap;
    out_ch.ready <= 1'b0;
    out_quiet = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      out_ch.ready <= 1'b1;
      run = $urandom_range(1, 24);
      repeat (run) @(posedge clk);
      gap = pick_gap(out_quiet);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    int ph;
    int i;
    int n;
    rst_n <= 1'b0;
    in_ch.valid             <= 1'b0;
    in_ch.core_index        <= '0;
    in_ch.active_count      <= '0;
    in_ch.productive_count  <= '0;
    in_ch.measured_freq_mhz <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.wr_index <= '0;
    cfg_ch.wr_data  <= '0;
    error_count = 0;
    items_taken = 0;
    requests_checked = 0;
    idle_cycles = 0;
    in_quiet = 0;
    for (i = 0; i < 4; i++) dec_seen[i] = 0;
    for (i = 0; i < NCORE; i++) begin
      hist_active[i] = '0;
      hist_productive[i] = '0;
      sent_active[i] = '0;
      sent_productive[i] = '0;
    end
    governor_cfg.low_th    = 11'd819;
    governor_cfg.high_th   = 11'd922;
    governor_cfg.boot_freq = 14'd2000;
    governor_cfg.max_freq  = 14'd2800;
    governor_cfg.min_freq  = 14'd1000;
    governor_cfg.step      = 10'd100;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (ph = 0; ph < NPHASE; ph++) begin
      if (ph == 0) begin
        for (i = 0; i < NDIR; i++) drive_sample(DIRECTED[i]);
        n = FIRST_RANDOM;
      end else begin
        wait_idle();
        program_phase(ph);
        @(posedge clk);
        n = PHASE_RANDOM;
      end
      for (i = 0; i < n; i++) drive_sample(gen_sample());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_requests.size() != 0) begin
      $error("%0d requests never arrived", pending_requests.size());
      error_count++;
    end
    $display("ran %0d sample items under %0d register settings, %0d requests checked",
             items_taken, NPHASE, requests_checked);
    $display("decisions seen: hold %0d, down %0d, up %0d, undefined ratio %0d",
             dec_seen[DEC_HOLD], dec_seen[DEC_DOWN], dec_seen[DEC_UP], dec_seen[DEC_UNDEF]);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/csfg_pkg.sv
design/csfg_intf.sv
design/csfg_cfg_regs.sv
design/csfg_hist.sv
design/core_scalability_freq_governor.sv
test/core_scalability_freq_governor_test.sv
